FILE: hw/rtl/rv32imf_instruction_decoder_defines.svh
// Assertion macros for the RV32IMF instruction decoder.
// No dependencies; included by the modules that carry assertions.
`ifndef RV32IMF_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32IMF_INSTRUCTION_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define RVDEC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rvdec check failed");
// Same-cycle implication checked outside reset.
`define RVDEC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvdec implication failed");
`else
`define RVDEC_ASSERT(label, clk, rst, prop)
`define RVDEC_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/rvdec_pkg.sv
// Shared types, opcode constants and lookup tables for the RV32IMF decoder.
// No dependencies.
package rvdec_pkg;

  // Encoding formats
  typedef enum logic [2:0] {
    FMT_UNKNOWN = 3'd0, FMT_R = 3'd1, FMT_I = 3'd2, FMT_S = 3'd3,
    FMT_B = 3'd4, FMT_U = 3'd5, FMT_J = 3'd6, FMT_R4 = 3'd7
  } fmt_t;

  // Dense mnemonic codes
  typedef enum logic [6:0] {
    OP_UNKNOWN = 7'd0, OP_ZERO = 7'd1,
    OP_LUI = 7'd2, OP_AUIPC = 7'd3, OP_JAL = 7'd4, OP_JALR = 7'd5,
    OP_BEQ = 7'd6, OP_BNE = 7'd7, OP_BLT = 7'd8, OP_BGE = 7'd9,
    OP_BLTU = 7'd10, OP_BGEU = 7'd11,
    OP_LB = 7'd12, OP_LH = 7'd13, OP_LW = 7'd14, OP_LBU = 7'd15, OP_LHU = 7'd16,
    OP_SB = 7'd17, OP_SH = 7'd18, OP_SW = 7'd19,
    OP_ADDI = 7'd20, OP_SLLI = 7'd21, OP_SLTI = 7'd22, OP_SLTIU = 7'd23,
    OP_XORI = 7'd24, OP_SRLI = 7'd25, OP_SRAI = 7'd26, OP_ORI = 7'd27,
    OP_ANDI = 7'd28,
    OP_ADD = 7'd29, OP_MUL = 7'd30, OP_SUB = 7'd31, OP_SLL = 7'd32,
    OP_MULH = 7'd33, OP_SLT = 7'd34, OP_MULHSU = 7'd35, OP_SLTU = 7'd36,
    OP_MULHU = 7'd37, OP_XOR = 7'd38, OP_DIV = 7'd39, OP_SRL = 7'd40,
    OP_DIVU = 7'd41, OP_SRA = 7'd42, OP_OR = 7'd43, OP_REM = 7'd44,
    OP_AND = 7'd45, OP_REMU = 7'd46,
    OP_FENCE = 7'd47, OP_ECALL = 7'd48, OP_EBREAK = 7'd49,
    OP_FLW = 7'd50, OP_FSW = 7'd51,
    OP_FMADD = 7'd52, OP_FMSUB = 7'd53, OP_FNMSUB = 7'd54, OP_FNMADD = 7'd55,
    OP_FADD = 7'd56, OP_FSUB = 7'd57, OP_FMUL = 7'd58, OP_FDIV = 7'd59,
    OP_FSQRT = 7'd60, OP_FSGNJ = 7'd61, OP_FSGNJN = 7'd62, OP_FSGNJX = 7'd63,
    OP_FMIN = 7'd64, OP_FMAX = 7'd65, OP_FCVT_W_S = 7'd66, OP_FCVT_WU_S = 7'd67,
    OP_FMV_X_W = 7'd68, OP_FCLASS = 7'd69, OP_FLE = 7'd70, OP_FLT = 7'd71,
    OP_FEQ = 7'd72, OP_FCVT_S_W = 7'd73, OP_FCVT_S_WU = 7'd74, OP_FMV_W_X = 7'd75
  } op_t;

  // Major opcodes, bits 6:0
  localparam logic [6:0] OPC_LUI      = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC    = 7'b0010111;
  localparam logic [6:0] OPC_JAL      = 7'b1101111;
  localparam logic [6:0] OPC_JALR     = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
  localparam logic [6:0] OPC_LOAD     = 7'b0000011;
  localparam logic [6:0] OPC_STORE    = 7'b0100011;
  localparam logic [6:0] OPC_OP_IMM   = 7'b0010011;
  localparam logic [6:0] OPC_OP       = 7'b0110011;
  localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
  localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;
  localparam logic [6:0] OPC_LOAD_FP  = 7'b0000111;
  localparam logic [6:0] OPC_STORE_FP = 7'b0100111;
  localparam logic [6:0] OPC_MADD     = 7'b1000011;
  localparam logic [6:0] OPC_MSUB     = 7'b1000111;
  localparam logic [6:0] OPC_NMSUB    = 7'b1001011;
  localparam logic [6:0] OPC_NMADD    = 7'b1001111;
  localparam logic [6:0] OPC_OP_FP    = 7'b1010011;

  // funct7 selectors
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_MEXT    = 7'h01;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [6:0] F7_FADD    = 7'h00;
  localparam logic [6:0] F7_FSUB    = 7'h04;
  localparam logic [6:0] F7_FMUL    = 7'h08;
  localparam logic [6:0] F7_FDIV    = 7'h0C;
  localparam logic [6:0] F7_FSQRT   = 7'h2C;
  localparam logic [6:0] F7_FSGNJ   = 7'h10;
  localparam logic [6:0] F7_FMINMAX = 7'h14;
  localparam logic [6:0] F7_FCVT_WS = 7'h60;
  localparam logic [6:0] F7_FMV_XW  = 7'h70;
  localparam logic [6:0] F7_FCMP    = 7'h50;
  localparam logic [6:0] F7_FCVT_SW = 7'h68;
  localparam logic [6:0] F7_FMV_WX  = 7'h78;

  // funct3 selectors with special handling
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_SHR     = 3'd5;

  // System immediates
  localparam logic [11:0] SYS_ECALL  = 12'd0;
  localparam logic [11:0] SYS_EBREAK = 12'd1;

  // funct3-indexed mnemonic tables
  localparam op_t BR_TBL [8] = '{OP_BEQ, OP_BNE, OP_UNKNOWN, OP_UNKNOWN,
                                 OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
  localparam op_t LD_TBL [8] = '{OP_LB, OP_LH, OP_LW, OP_UNKNOWN,
                                 OP_LBU, OP_LHU, OP_UNKNOWN, OP_UNKNOWN};
  localparam op_t ST_TBL [8] = '{OP_SB, OP_SH, OP_SW, OP_UNKNOWN,
                                 OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN};
  localparam op_t ALUI_TBL [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU,
                                   OP_XORI, OP_UNKNOWN, OP_ORI, OP_ANDI};
  localparam op_t ALU_TBL [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                  OP_XOR, OP_SRL, OP_OR, OP_AND};
  localparam op_t MEXT_TBL [8] = '{OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
                                   OP_DIV, OP_DIVU, OP_REM, OP_REMU};
  localparam op_t FSGNJ_TBL [8] = '{OP_FSGNJ, OP_FSGNJN, OP_FSGNJX, OP_UNKNOWN,
                                    OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN};
  localparam op_t FMINMAX_TBL [8] = '{OP_FMIN, OP_FMAX, OP_UNKNOWN, OP_UNKNOWN,
                                      OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN};
  localparam op_t FMVCLS_TBL [8] = '{OP_FMV_X_W, OP_FCLASS, OP_UNKNOWN, OP_UNKNOWN,
                                     OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN};
  localparam op_t FCMP_TBL [8] = '{OP_FLE, OP_FLT, OP_FEQ, OP_UNKNOWN,
                                   OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN};

  // Format-level fields of one decoded word
  typedef struct packed {
    fmt_t        fmt;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  rs3;
    logic [31:0] imm;
    logic        mem_style;
  } fields_t;

endpackage

FILE: hw/rtl/rv32imf_instruction_decoder.sv
// RV32IMF instruction decoder top level: three-stage pipeline with stall.
// Depends on rvdec_pkg, rvdec_fmt_decode, rvdec_op_decode and the defines header.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per instruction:
//   instr_word and its address pc. Output channel (out_valid / out_stall)
//   carries one result beat: format, mnemonic code, used register fields,
//   sign-extended immediate, branch target (pc plus B immediate, wrapping
//   at 64 bits) and the offset(base) operand flag.
//   An accepted input beat passes the stage 1, 2 and 3 registers on its way to
//   out_valid. Throughput is one beat per cycle while out_stall is low:
//   stage 1 decodes format and immediate, stage 2 the mnemonic and the low
//   half of the target add, stage 3 the high half of the target add.
//   Each stage advances when it is empty or the stage after it is moving, so
//   out_stall freezes a full pipeline in place and backs up into in_stall;
//   no beat is dropped or repeated. Synchronous reset (rst) empties all
//   stages; payload registers are not reset.
`include "rv32imf_instruction_decoder_defines.svh"
module rv32imf_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        instr_word,
  input  logic [63:0]        pc,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         operand_format,
  output logic [6:0]         op_code,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic [4:0]         src3_reg,
  output logic signed [31:0] immediate,
  output logic [63:0]        branch_target,
  output logic               mem_style
);
  import rvdec_pkg::*;

  // Stage valids and advance enables
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3     = !v3 || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  // Stage 1: format fields
  fields_t     fld_in;
  fields_t     fld1;
  logic [31:0] word1;
  logic [63:0] pc1;

  rvdec_fmt_decode u_fmt (
    .instr_word (instr_word),
    .fields     (fld_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      fld1  <= fld_in;
      word1 <= instr_word;
      pc1   <= pc;
    end
  end

  // Stage 2: mnemonic and low half of the target add
  op_t         op_s1;
  fields_t     fld2;
  op_t         op2;
  logic [31:0] pc_hi2;
  logic [32:0] lo_sum2;

  rvdec_op_decode u_op (
    .instr_word (word1),
    .op_code    (op_s1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      fld2    <= fld1;
      op2     <= op_s1;
      pc_hi2  <= pc1[63:32];
      lo_sum2 <= {1'b0, pc1[31:0]} + {1'b0, fld1.imm};
    end
  end

  // Stage 3: high half of the target add, output registers
  logic [31:0] hi_sum;
  fields_t     fld3;
  op_t         op3;
  logic [63:0] target3;

  assign hi_sum = pc_hi2 + {32{fld2.imm[31]}} + {31'd0, lo_sum2[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      fld3    <= fld2;
      op3     <= op2;
      target3 <= (fld2.fmt == FMT_B) ? {hi_sum, lo_sum2[31:0]} : 64'd0;
    end
  end

  // Output beat
  assign out_valid      = v3;
  assign operand_format = fld3.fmt;
  assign op_code        = op3;
  assign dest_reg       = fld3.rd;
  assign src1_reg       = fld3.rs1;
  assign src2_reg       = fld3.rs2;
  assign src3_reg       = fld3.rs3;
  assign immediate      = $signed(fld3.imm);
  assign branch_target  = target3;
  assign mem_style      = fld3.mem_style;

  // Checks
  `RVDEC_ASSERT(a_latency, clk, rst, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
  `RVDEC_ASSERT_IMP(a_unknown_clear, clk, rst, out_valid && operand_format == FMT_UNKNOWN, dest_reg == 5'd0 && src1_reg == 5'd0 && src2_reg == 5'd0 && immediate == 32'sd0)
  `RVDEC_ASSERT_IMP(a_target_fmt, clk, rst, out_valid && branch_target != 64'd0, operand_format == FMT_B)
  `RVDEC_ASSERT_IMP(a_mem_fmt, clk, rst, out_valid && mem_style, operand_format == FMT_I || operand_format == FMT_S)

endmodule

FILE: hw/rtl/rvdec_fmt_decode.sv
// Format decode: encoding format, used register fields, immediate, mem style.
// Depends on rvdec_pkg.
module rvdec_fmt_decode (
  input  logic [31:0]        instr_word,
  output rvdec_pkg::fields_t fields
);
  import rvdec_pkg::*;

  logic [6:0] opc;
  fmt_t       fmt;

  assign opc = instr_word[6:0];

  // Format follows the major opcode alone
  always_comb begin
    case (opc)
      OPC_LUI, OPC_AUIPC: fmt = FMT_U;
      OPC_JAL: fmt = FMT_J;
      OPC_JALR, OPC_LOAD, OPC_OP_IMM, OPC_MISC_MEM, OPC_SYSTEM, OPC_LOAD_FP: fmt = FMT_I;
      OPC_BRANCH: fmt = FMT_B;
      OPC_STORE, OPC_STORE_FP: fmt = FMT_S;
      OPC_OP, OPC_OP_FP: fmt = FMT_R;
      OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: fmt = FMT_R4;
      default: fmt = FMT_UNKNOWN;
    endcase
  end

  // Register fields the format uses, immediate assembled per format
  always_comb begin
    fields.fmt = fmt;
    fields.rd  = '0;
    fields.rs1 = '0;
    fields.rs2 = '0;
    fields.rs3 = '0;
    fields.imm = '0;
    // offset(base) operand style: loads, jalr, stores
    fields.mem_style = opc inside {OPC_LOAD, OPC_LOAD_FP, OPC_JALR,
                                   OPC_STORE, OPC_STORE_FP};
    case (fmt)
      FMT_R: begin
        fields.rd  = instr_word[11:7];
        fields.rs1 = instr_word[19:15];
        fields.rs2 = instr_word[24:20];
      end
      FMT_R4: begin
        fields.rd  = instr_word[11:7];
        fields.rs1 = instr_word[19:15];
        fields.rs2 = instr_word[24:20];
        fields.rs3 = instr_word[31:27];
      end
      FMT_I: begin
        fields.rd  = instr_word[11:7];
        fields.rs1 = instr_word[19:15];
        fields.imm = {{20{instr_word[31]}}, instr_word[31:20]};
      end
      FMT_S: begin
        fields.rs1 = instr_word[19:15];
        fields.rs2 = instr_word[24:20];
        fields.imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
      end
      FMT_B: begin
        fields.rs1 = instr_word[19:15];
        fields.rs2 = instr_word[24:20];
        fields.imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                      instr_word[30:25], instr_word[11:8], 1'b0};
      end
      FMT_U: begin
        fields.rd  = instr_word[11:7];
        fields.imm = {instr_word[31:12], 12'b0};
      end
      FMT_J: begin
        fields.rd  = instr_word[11:7];
        fields.imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                      instr_word[20], instr_word[30:21], 1'b0};
      end
      default: begin
        fields.rd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/rvdec_op_decode.sv
// Mnemonic decode: maps opcode, funct3, funct7 and rs2 selector to a dense code.
// Depends on rvdec_pkg.
module rvdec_op_decode (
  input  logic [31:0]     instr_word,
  output rvdec_pkg::op_t  op_code
);
  import rvdec_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  r2;
  logic [11:0] sys_imm;
  logic        r2_low;  // rs2 selector is 0 or 1

  assign opc     = instr_word[6:0];
  assign f3      = instr_word[14:12];
  assign f7      = instr_word[31:25];
  assign r2      = instr_word[24:20];
  assign sys_imm = instr_word[31:20];
  assign r2_low  = (r2[4:1] == 4'd0);

  // Floating-point operate group, selected by funct7
  function automatic op_t fp_op(input logic [6:0] sel, input logic [2:0] fn3,
                                input logic sel_ok, input logic sel_bit);
    op_t res;
    res = OP_UNKNOWN;
    case (sel)
      F7_FADD:    res = OP_FADD;
      F7_FSUB:    res = OP_FSUB;
      F7_FMUL:    res = OP_FMUL;
      F7_FDIV:    res = OP_FDIV;
      F7_FSQRT:   res = OP_FSQRT;
      F7_FSGNJ:   res = FSGNJ_TBL[fn3];
      F7_FMINMAX: res = FMINMAX_TBL[fn3];
      F7_FCVT_WS: res = sel_ok ? (sel_bit ? OP_FCVT_WU_S : OP_FCVT_W_S) : OP_UNKNOWN;
      F7_FMV_XW:  res = FMVCLS_TBL[fn3];
      F7_FCMP:    res = FCMP_TBL[fn3];
      F7_FCVT_SW: res = sel_ok ? (sel_bit ? OP_FCVT_S_WU : OP_FCVT_S_W) : OP_UNKNOWN;
      F7_FMV_WX:  res = OP_FMV_W_X;
      default:    res = OP_UNKNOWN;
    endcase
    return res;
  endfunction

  // Major opcode dispatch
  always_comb begin
    case (opc)
      OPC_LUI:    op_code = OP_LUI;
      OPC_AUIPC:  op_code = OP_AUIPC;
      OPC_JAL:    op_code = OP_JAL;
      OPC_JALR:   op_code = OP_JALR;
      OPC_BRANCH: op_code = BR_TBL[f3];
      OPC_LOAD:   op_code = LD_TBL[f3];
      OPC_STORE:  op_code = ST_TBL[f3];
      OPC_OP_IMM: begin
        if (f3 == F3_SHR) begin
          op_code = (f7 == F7_BASE) ? OP_SRLI : ((f7 == F7_ALT) ? OP_SRAI : OP_UNKNOWN);
        end else begin
          op_code = ALUI_TBL[f3];
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          op_code = ALU_TBL[f3];
        end else if (f7 == F7_MEXT) begin
          op_code = MEXT_TBL[f3];
        end else if (f7 == F7_ALT && f3 == F3_ADD_SUB) begin
          op_code = OP_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SHR) begin
          op_code = OP_SRA;
        end else begin
          op_code = OP_UNKNOWN;
        end
      end
      OPC_MISC_MEM: op_code = OP_FENCE;
      OPC_SYSTEM: begin
        op_code = (sys_imm == SYS_ECALL) ? OP_ECALL :
                  ((sys_imm == SYS_EBREAK) ? OP_EBREAK : OP_UNKNOWN);
      end
      OPC_LOAD_FP:  op_code = OP_FLW;
      OPC_STORE_FP: op_code = OP_FSW;
      OPC_MADD:     op_code = OP_FMADD;
      OPC_MSUB:     op_code = OP_FMSUB;
      OPC_NMSUB:    op_code = OP_FNMSUB;
      OPC_NMADD:    op_code = OP_FNMADD;
      OPC_OP_FP:    op_code = fp_op(f7, f3, r2_low, r2[0]);
      default:      op_code = (instr_word == 32'd0) ? OP_ZERO : OP_UNKNOWN;
    endcase
  end

endmodule

FILE: bench/tb_top.sv
// Testbench for the RV32IMF instruction decoder: directed words, a mnemonic sweep,
// random streams and back-pressure, each result checked field by field.
// Depends on rvdec_pkg and the rv32imf_instruction_decoder RTL.
module tb_top;
  import rvdec_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int LONG_HOLD   = 80;

  // Major opcodes the decoder knows
  localparam logic [6:0] MAJOR_OPCODES [18] = '{
    OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
    OPC_OP_IMM, OPC_OP, OPC_MISC_MEM, OPC_SYSTEM, OPC_LOAD_FP, OPC_STORE_FP,
    OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD, OPC_OP_FP};
  localparam logic [6:0] ALU_F7 [3] = '{F7_BASE, F7_MEXT, F7_ALT};
  localparam logic [6:0] FP_F7 [12] = '{
    F7_FADD, F7_FSUB, F7_FMUL, F7_FDIV, F7_FSQRT, F7_FSGNJ, F7_FMINMAX,
    F7_FCVT_WS, F7_FMV_XW, F7_FCMP, F7_FCVT_SW, F7_FMV_WX};

  // Mnemonics selected by funct3
  localparam op_t BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_UNKNOWN, OP_UNKNOWN,
                                     OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
  localparam op_t LOAD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_UNKNOWN,
                                   OP_LBU, OP_LHU, OP_UNKNOWN, OP_UNKNOWN};
  localparam op_t STORE_OPS [8] = '{OP_SB, OP_SH, OP_SW, OP_UNKNOWN,
                                    OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN};
  localparam op_t IMM_OPS [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU,
                                  OP_XORI, OP_UNKNOWN, OP_ORI, OP_ANDI};
  localparam op_t REG_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                  OP_XOR, OP_SRL, OP_OR, OP_AND};
  localparam op_t MULDIV_OPS [8] = '{OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
                                     OP_DIV, OP_DIVU, OP_REM, OP_REMU};
  localparam op_t SGNJ_OPS [3] = '{OP_FSGNJ, OP_FSGNJN, OP_FSGNJX};
  localparam op_t CMP_OPS [3] = '{OP_FLE, OP_FLT, OP_FEQ};

  typedef struct {
    logic [31:0] word;
    fmt_t        fmt;
    op_t         op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  rs3;
    logic [31:0] imm;
    logic [63:0] target;
    logic        mem;
  } decode_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        instr_word;
  logic [63:0]        pc;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         operand_format;
  logic [6:0]         op_code;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic [4:0]         src3_reg;
  logic signed [31:0] immediate;
  logic [63:0]        branch_target;
  logic               mem_style;

  decode_t pending_decodes[$];
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  int      stall_hold_cycles = 0;
  bit      tx_gaps_on = 1'b1;
  bit      rx_gaps_on = 1'b1;

  rv32imf_instruction_decoder dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Expected decode of one instruction word
  function automatic decode_t predict_decode(input logic [31:0] w, input logic [63:0] addr);
    decode_t d;
    logic [6:0] opc;
    logic [6:0] f7;
    logic [2:0] f3;
    opc = w[6:0];
    f3 = w[14:12];
    f7 = w[31:25];
    d.word = w;
    d.fmt = FMT_UNKNOWN;
    d.op = OP_UNKNOWN;
    d.rd = '0;
    d.rs1 = '0;
    d.rs2 = '0;
    d.rs3 = '0;
    d.imm = '0;
    d.target = '0;
    d.mem = (opc == OPC_LOAD) || (opc == OPC_LOAD_FP) || (opc == OPC_JALR) ||
            (opc == OPC_STORE) || (opc == OPC_STORE_FP);

    // format follows the major opcode alone
    case (opc)
      OPC_LUI, OPC_AUIPC: d.fmt = FMT_U;
      OPC_JAL: d.fmt = FMT_J;
      OPC_JALR, OPC_LOAD, OPC_OP_IMM, OPC_MISC_MEM, OPC_SYSTEM, OPC_LOAD_FP: d.fmt = FMT_I;
      OPC_BRANCH: d.fmt = FMT_B;
      OPC_STORE, OPC_STORE_FP: d.fmt = FMT_S;
      OPC_OP, OPC_OP_FP: d.fmt = FMT_R;
      OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: d.fmt = FMT_R4;
      default: d.fmt = FMT_UNKNOWN;
    endcase

    // register fields and immediate; unused ones stay zero
    case (d.fmt)
      FMT_R: begin
        d.rd = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
      end
      FMT_R4: begin
        d.rd = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.rs3 = w[31:27];
      end
      FMT_I: begin
        d.rd = w[11:7];
        d.rs1 = w[19:15];
        d.imm = {{20{w[31]}}, w[31:20]};
      end
      FMT_S: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      FMT_B: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        d.target = addr + {{32{d.imm[31]}}, d.imm};
      end
      FMT_U: begin
        d.rd = w[11:7];
        d.imm = {w[31:12], 12'h000};
      end
      FMT_J: begin
        d.rd = w[11:7];
        d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      default: ;
    endcase

    // mnemonic from opcode, funct3, funct7 and the rs2 selector
    case (opc)
      OPC_LUI: d.op = OP_LUI;
      OPC_AUIPC: d.op = OP_AUIPC;
      OPC_JAL: d.op = OP_JAL;
      OPC_JALR: d.op = OP_JALR;
      OPC_BRANCH: d.op = BRANCH_OPS[f3];
      OPC_LOAD: d.op = LOAD_OPS[f3];
      OPC_STORE: d.op = STORE_OPS[f3];
      OPC_OP_IMM: begin
        if (f3 != F3_SHR) d.op = IMM_OPS[f3];
        else if (f7 == F7_BASE) d.op = OP_SRLI;
        else if (f7 == F7_ALT) d.op = OP_SRAI;
      end
      OPC_OP: begin
        if (f7 == F7_BASE) d.op = REG_OPS[f3];
        else if (f7 == F7_MEXT) d.op = MULDIV_OPS[f3];
        else if (f7 == F7_ALT && f3 == F3_ADD_SUB) d.op = OP_SUB;
        else if (f7 == F7_ALT && f3 == F3_SHR) d.op = OP_SRA;
      end
      OPC_MISC_MEM: d.op = OP_FENCE;
      OPC_SYSTEM: begin
        if (w[31:20] == SYS_ECALL) d.op = OP_ECALL;
        else if (w[31:20] == SYS_EBREAK) d.op = OP_EBREAK;
      end
      OPC_LOAD_FP: d.op = OP_FLW;
      OPC_STORE_FP: d.op = OP_FSW;
      OPC_MADD: d.op = OP_FMADD;
      OPC_MSUB: d.op = OP_FMSUB;
      OPC_NMSUB: d.op = OP_FNMSUB;
      OPC_NMADD: d.op = OP_FNMADD;
      OPC_OP_FP: begin
        case (f7)
          F7_FADD: d.op = OP_FADD;
          F7_FSUB: d.op = OP_FSUB;
          F7_FMUL: d.op = OP_FMUL;
          F7_FDIV: d.op = OP_FDIV;
          F7_FSQRT: d.op = OP_FSQRT;
          F7_FSGNJ: if (f3 <= 3'd2) d.op = SGNJ_OPS[f3];
          F7_FMINMAX: if (f3[2:1] == 2'b00) d.op = f3[0] ? OP_FMAX : OP_FMIN;
          F7_FCVT_WS: if (w[24:21] == 4'h0) d.op = w[20] ? OP_FCVT_WU_S : OP_FCVT_W_S;
          F7_FMV_XW: if (f3[2:1] == 2'b00) d.op = f3[0] ? OP_FCLASS : OP_FMV_X_W;
          F7_FCMP: if (f3 <= 3'd2) d.op = CMP_OPS[f3];
          F7_FCVT_SW: if (w[24:21] == 4'h0) d.op = w[20] ? OP_FCVT_S_WU : OP_FCVT_S_W;
          F7_FMV_WX: d.op = OP_FMV_W_X;
          default: d.op = OP_UNKNOWN;
        endcase
      end
      default: if (w == 32'h0) d.op = OP_ZERO;
    endcase
    return d;
  endfunction

  // Random word: mostly well-formed encodings with random content, some noise
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 3) return 32'h0;
    if (pick < 12) return w;
    if (pick < 30) begin
      w[6:0] = OPC_OP_FP;
      w[31:25] = FP_F7[$urandom_range(0, 11)];
      if ($urandom_range(0, 1) == 1) w[14:12] = 3'($urandom_range(0, 2));
      if ($urandom_range(0, 3) != 0) w[24:21] = 4'h0;
      return w;
    end
    w[6:0] = MAJOR_OPCODES[$urandom_range(0, 17)];
    if ((w[6:0] == OPC_OP || w[6:0] == OPC_OP_IMM) && $urandom_range(0, 3) != 0)
      w[31:25] = ALU_F7[$urandom_range(0, 2)];
    if (w[6:0] == OPC_SYSTEM && $urandom_range(0, 1) == 1)
      w[31:21] = '0;
    return w;
  endfunction

  // Random address with the wrap extremes now and then
  function automatic logic [63:0] rand_pc();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Drop valid and sit out a number of cycles
  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Offer one beat, hold it until taken, queue its decode
  task automatic send_word(input logic [31:0] w, input logic [63:0] addr);
    instr_word <= w;
    pc <= addr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_decodes.push_back(predict_decode(w, addr));
    if (tx_gaps_on && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 14));
  endtask

  // Field extremes and the corner encodings
  task automatic test_directed_words();
    send_word(32'h0000_0000, 64'h0);                          // all-zero word
    send_word(32'hFFFF_FFFF, '1);                             // unlisted opcode, all ones
    send_word(32'h0000_0080, rand_pc());                      // nonzero, unlisted opcode
    send_word({20'hFFFFF, 5'd31, OPC_LUI}, rand_pc());
    send_word({20'h80000, 5'd0, OPC_AUIPC}, rand_pc());
    send_word({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, rand_pc());  // most negative
    send_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL}, rand_pc()); // most positive
    send_word({12'hFFF, 5'd31, 3'b000, 5'd1, OPC_JALR}, rand_pc());
    // backward branch below zero and forward branch past the top
    send_word({1'b1, 6'h00, 5'd0, 5'd31, 3'b000, 4'h0, 1'b0, OPC_BRANCH}, 64'h0);
    send_word({1'b0, 6'h3F, 5'd31, 5'd0, 3'b111, 4'hF, 1'b1, OPC_BRANCH}, '1);
    send_word({1'b0, 6'h20, 5'd1, 5'd2, 3'b001, 4'h0, 1'b0, OPC_BRANCH}, rand_pc());
    send_word({7'h55, 5'd3, 5'd4, 3'b010, 5'h0B, OPC_BRANCH}, rand_pc());
    send_word({12'h800, 5'd7, 3'b100, 5'd8, OPC_LOAD}, rand_pc());
    send_word({7'h40, 5'd31, 5'd31, 3'b010, 5'h00, OPC_STORE}, rand_pc());
    send_word({F7_ALT, 5'd31, 5'd1, F3_SHR, 5'd2, OPC_OP_IMM}, rand_pc());
    send_word({7'h7F, 5'd1, 5'd1, F3_SHR, 5'd1, OPC_OP_IMM}, rand_pc());
    send_word({F7_ALT, 5'd31, 5'd30, F3_ADD_SUB, 5'd29, OPC_OP}, rand_pc());
    send_word({F7_MEXT, 5'd0, 5'd31, 3'b111, 5'd31, OPC_OP}, rand_pc());
    send_word({F7_ALT, 5'd1, 5'd2, 3'b001, 5'd3, OPC_OP}, rand_pc());
    // environment calls: other bits are ignored, any other immediate is unknown
    send_word({SYS_ECALL, 13'h0000, OPC_SYSTEM}, rand_pc());
    send_word({SYS_EBREAK, 5'd31, 3'b111, 5'd31, OPC_SYSTEM}, rand_pc());
    send_word({12'h002, 13'h0000, OPC_SYSTEM}, rand_pc());
    send_word({12'hFFF, 13'h1FFF, OPC_MISC_MEM}, rand_pc());
    send_word({5'd31, 2'b11, 5'd31, 5'd31, 3'b111, 5'd31, OPC_NMADD}, rand_pc());
    send_word({F7_FCVT_SW, 5'd2, 5'd1, 3'b000, 5'd1, OPC_OP_FP}, rand_pc());
    pause_input(1);
  endtask

  // Every major opcode with every funct3 and the listed funct7 selectors
  task automatic test_mnemonic_sweep();
    logic [31:0] w;
    foreach (MAJOR_OPCODES[i]) begin
      for (int f3 = 0; f3 < 8; f3++) begin
        w = $urandom;
        w[6:0] = MAJOR_OPCODES[i];
        w[14:12] = f3[2:0];
        if (MAJOR_OPCODES[i] == OPC_OP || MAJOR_OPCODES[i] == OPC_OP_IMM) begin
          foreach (ALU_F7[k]) begin
            w[31:25] = ALU_F7[k];
            send_word(w, rand_pc());
          end
        end else if (MAJOR_OPCODES[i] == OPC_OP_FP) begin
          foreach (FP_F7[k]) begin
            w[31:25] = FP_F7[k];
            w[24:21] = 4'h0;
            w[20] = 1'($urandom_range(0, 1));
            send_word(w, rand_pc());
          end
        end else begin
          if (MAJOR_OPCODES[i] == OPC_SYSTEM) w[31:21] = '0;
          send_word(w, rand_pc());
        end
      end
    end
    pause_input(1);
  endtask

  // Receiver holds off long while the sender keeps offering beats
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    stall_hold_cycles = LONG_HOLD;
    while (!out_stall) @(posedge clk);
    repeat (40) send_word(rand_word(), rand_pc());
    pause_input(1);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Sender stops until the pipeline has drained, then resumes
  task automatic test_drain_pause();
    repeat (30) send_word(rand_word(), rand_pc());
    pause_input(0);
    do @(posedge clk); while (pending_decodes.size() != 0);
    repeat (30) send_word(rand_word(), rand_pc());
    pause_input(1);
  endtask

  task automatic test_random_stream(input int count, input bit with_gaps);
    tx_gaps_on = with_gaps;
    rx_gaps_on = with_gaps;
    repeat (count) send_word(rand_word(), rand_pc());
    pause_input(1);
  endtask

  // Receiver: random stall bursts, or one long hold on request
  initial begin
    forever begin
      if (stall_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_hold_cycles) @(posedge clk);
        stall_hold_cycles = 0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got, input logic [31:0] w);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: word %h %s mismatch: expected %h, got %h", $time, w, name, want, got);
    end
  endtask

  // Compare each taken result beat with the oldest pending decode
  always @(posedge clk) begin : result_check
    decode_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat: expected none, got op_code %0d",
                 $time, op_code);
      end else begin
        e = pending_decodes.pop_front();
        check_field("operand_format", 64'(e.fmt), 64'(operand_format), e.word);
        check_field("op_code", 64'(e.op), 64'(op_code), e.word);
        check_field("dest_reg", 64'(e.rd), 64'(dest_reg), e.word);
        check_field("src1_reg", 64'(e.rs1), 64'(src1_reg), e.word);
        check_field("src2_reg", 64'(e.rs2), 64'(src2_reg), e.word);
        check_field("src3_reg", 64'(e.rs3), 64'(src3_reg), e.word);
        check_field("immediate", 64'(e.imm), 64'($unsigned(immediate)), e.word);
        check_field("branch_target", e.target, branch_target, e.word);
        check_field("mem_style", 64'(e.mem), 64'(mem_style), e.word);
      end
    end
  end

  // Watchdog on cycles with no beat taken on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    instr_word <= '0;
    pc <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_words();
    test_mnemonic_sweep();
    test_output_backpressure();
    test_drain_pause();
    test_random_stream(300, 1'b1);
    test_random_stream(60, 1'b0);
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
